// ===== rtl/core/cia_pkg.sv =====
// Shared types, operation codes and helper functions for the checked integer ALU.
package cia_pkg;

  localparam int DataW = 64;
  localparam int CmdW = 5;
  localparam int UserW = 12;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW = $clog2(QueueDepth);

  // Width codes for operands and for the operation.
  localparam logic [1:0] WC16 = 2'd0;
  localparam logic [1:0] WC32 = 2'd1;
  localparam logic [1:0] WC64 = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_OVF = 2'd1;
  localparam logic [1:0] ERR_DIV0 = 2'd2;

  typedef enum logic [CmdW-1:0] {
    OP_ADD = 5'd0,
    OP_SUB = 5'd1,
    OP_MUL = 5'd2,
    OP_DIV = 5'd3,
    OP_MOD = 5'd4,
    OP_ABS = 5'd5,
    OP_INC = 5'd6,
    OP_DEC = 5'd7,
    OP_AND = 5'd8,
    OP_OR  = 5'd9,
    OP_XOR = 5'd10,
    OP_NOT = 5'd11,
    OP_SHL = 5'd12,
    OP_SHR = 5'd13,
    OP_EQ  = 5'd14,
    OP_NE  = 5'd15,
    OP_LT  = 5'd16,
    OP_LE  = 5'd17,
    OP_GT  = 5'd18,
    OP_GE  = 5'd19,
    OP_CMP = 5'd20,
    OP_MAX = 5'd21,
    OP_MIN = 5'd22
  } op_t;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [1:0]       wop;
    logic             uc;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } item_t;

  // Sign-extend from the width given by a width code; code three is 64 bits.
  function automatic logic [DataW-1:0] sext(input logic [DataW-1:0] v,
                                            input logic [1:0] wc);
    logic [DataW-1:0] r;
    case (wc)
      WC16:    r = {{(DataW-16){v[15]}}, v[15:0]};
      WC32:    r = {{(DataW-32){v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  // Weight of the sign bit at the given width, as an unsigned value.
  function automatic logic [DataW-1:0] half_of(input logic [1:0] wc);
    logic [DataW-1:0] r;
    case (wc)
      WC16:    r = 64'h0000_0000_0000_8000;
      WC32:    r = 64'h0000_0000_8000_0000;
      default: r = 64'h8000_0000_0000_0000;
    endcase
    return r;
  endfunction

  // Two's complement magnitude.
  function automatic logic [DataW-1:0] mag(input logic [DataW-1:0] v);
    return v[DataW-1] ? (~v + 64'd1) : v;
  endfunction

endpackage

// ===== rtl/core/checked_integer_alu.sv =====
// Top level of the checked integer ALU: front stage, queue and execution stage.
// One operation enters per transfer and yields exactly one result, in order. Logic, shift,
// add, subtract, compare and increment/decrement operations are accepted at one per cycle
// while the queue has room, passing through the front register, queue and output register.
// Multiply runs four 32x32 partial products through one shared multiplier and occupies the
// execution stage while it runs; divide and modulo use a one-bit-per-cycle restoring divider
// that occupies it in the same way. A four-entry queue lets the input keep accepting
// while the execution stage is busy. Errors return a zero value with the error code set.
module checked_integer_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: operand_a[63:0], operand_b[127:64].
  input  logic [2*cia_pkg::DataW-1:0] s_axis_tdata,
  // Fields from bit 0: command[4:0], width_a[6:5], width_b[8:7], width_op[10:9],
  // unsigned_compare[11].
  input  logic [cia_pkg::UserW-1:0]   s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: result_value[63:0].
  output logic [cia_pkg::DataW-1:0]   m_axis_tdata,
  // Fields from bit 0: error_code[1:0].
  output logic [1:0]  m_axis_tuser
);
  import cia_pkg::*;

  logic  f_valid;
  logic  q_not_full;
  item_t f_item;
  logic  q_not_empty;
  logic  q_pop;
  item_t q_head;

  // Front stage.
  cia_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_user    (s_axis_tuser),
    .in_data    (s_axis_tdata),
    .item_valid (f_valid),
    .item_ready (q_not_full),
    .item       (f_item)
  );

  // Decoupling queue.
  cia_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid && q_not_full),
    .push_item (f_item),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Execution stage.
  cia_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_not_empty),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (m_axis_tdata),
    .out_err   (m_axis_tuser)
  );

endmodule

// ===== rtl/core/cia_front.sv =====
// Front stage: takes a transfer, narrows and sign-extends the operands, registers the item.
module cia_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [cia_pkg::UserW-1:0] in_user,
  input  logic [2*cia_pkg::DataW-1:0] in_data,
  output logic                      item_valid,
  input  logic                      item_ready,
  output cia_pkg::item_t            item
);
  import cia_pkg::*;

  logic  valid;
  item_t held;
  item_t decoded;
  logic [1:0] wop;

  // Classify the incoming transfer.
  always_comb begin
    wop = (in_user[10:9] == 2'd3) ? WC64 : in_user[10:9];
    decoded.cmd = in_user[4:0];
    decoded.wop = wop;
    decoded.uc  = in_user[11] && (wop == WC32);
    decoded.a   = sext(sext(in_data[DataW-1:0], in_user[6:5]), wop);
    decoded.b   = sext(sext(in_data[2*DataW-1:DataW], in_user[8:7]), wop);
  end

  assign in_ready   = !valid || item_ready;
  assign item_valid = valid;
  assign item       = held;

  // Holding register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held <= decoded;
    end
  end

endmodule

// ===== rtl/core/cia_queue.sv =====
// Short queue that decouples the front stage from the execution stage.
module cia_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cia_pkg::item_t push_item,
  output logic           not_full,
  input  logic           pop,
  output logic           not_empty,
  output cia_pkg::item_t head
);
  import cia_pkg::*;

  item_t store [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueuePtrW:0]   count;

  assign not_full  = (count != (QueuePtrW+1)'(QueueDepth));
  assign not_empty = (count != '0);
  assign head      = store[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QueuePtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QueuePtrW'(1);
      end
      if (push && !pop) begin
        count <= count + (QueuePtrW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QueuePtrW+1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/core/cia_back.sv =====
// Execution stage: single-cycle operations, iterative multiply and divide, output register.
module cia_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  cia_pkg::item_t            q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [cia_pkg::DataW-1:0] out_value,
  output logic [1:0]                out_err
);
  import cia_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;
  logic [6:0]         cnt;
  logic [CmdW-1:0]    cur_cmd;
  logic [1:0]         cur_wop;
  logic               cur_neg;
  logic               cur_a_neg;
  logic [DataW-1:0]   ma;
  logic [DataW-1:0]   mb;
  logic [2*DataW-1:0] acc;
  logic [DataW-1:0]   prod;
  logic [1:0]         prod_sh;
  logic [DataW:0]     rem;
  logic [DataW-1:0]   quo;
  logic [DataW-1:0]   res_value;
  logic [1:0]         res_err;

  logic             out_free;
  logic             out_load;
  logic [DataW-1:0] a, b, half, minw, maxw;
  logic             lt, eq, is_mul, is_long_div;
  logic [DataW-1:0] s_val;
  logic [1:0]       s_err;
  logic [DataW-1:0] sum, diff;
  logic [5:0]       sh_n;
  logic [31:0]      pa, pb;
  logic [DataW:0]   rem_sh;
  logic [DataW-1:0] lo, lim, mq;

  assign out_free = !out_valid || out_ready;

  // Single-cycle evaluation of the item at the head of the queue.
  always_comb begin
    a    = q_item.a;
    b    = q_item.b;
    half = half_of(q_item.wop);
    minw = sext(half, q_item.wop);
    maxw = half - 64'd1;
    lt   = q_item.uc ? (a[31:0] < b[31:0]) : ($signed(a) < $signed(b));
    eq   = (a == b);
    sum  = a + b;
    diff = a - b;
    case (q_item.wop)
      WC16:    sh_n = {2'b00, b[3:0]};
      WC32:    sh_n = {1'b0, b[4:0]};
      default: sh_n = b[5:0];
    endcase
    is_mul      = (q_item.cmd == OP_MUL);
    is_long_div = ((q_item.cmd == OP_DIV) || (q_item.cmd == OP_MOD)) && (b != '0) &&
                  !((a == minw) && (b == '1));
    s_val = '0;
    s_err = ERR_NONE;
    case (q_item.cmd)
      OP_ADD: begin
        s_val = sum;
        if (q_item.wop == WC16 || q_item.wop == WC32) begin
          if (sext(sum, q_item.wop) != sum) s_err = ERR_OVF;
        end else if ((a[63] == b[63]) && (sum[63] != a[63])) begin
          s_err = ERR_OVF;
        end
      end
      OP_SUB: begin
        s_val = diff;
        if (q_item.wop == WC16 || q_item.wop == WC32) begin
          if (sext(diff, q_item.wop) != diff) s_err = ERR_OVF;
        end else if ((a[63] != b[63]) && (diff[63] != a[63])) begin
          s_err = ERR_OVF;
        end
      end
      OP_DIV: begin
        // Only the divide-by-zero and minimum-by-minus-one cases reach here.
        s_err = (b == '0) ? ERR_DIV0 : ERR_OVF;
      end
      OP_MOD: begin
        s_err = (b == '0) ? ERR_DIV0 : ERR_NONE;
      end
      OP_ABS: begin
        if (a == minw) s_err = ERR_OVF;
        else s_val = mag(a);
      end
      OP_INC: begin
        if (a == maxw) s_err = ERR_OVF;
        else s_val = a + 64'd1;
      end
      OP_DEC: begin
        if (a == minw) s_err = ERR_OVF;
        else s_val = a - 64'd1;
      end
      OP_AND: s_val = a & b;
      OP_OR:  s_val = a | b;
      OP_XOR: s_val = a ^ b;
      OP_NOT: s_val = ~a;
      OP_SHL: s_val = a << sh_n;
      OP_SHR: s_val = DataW'($signed(a) >>> sh_n);
      OP_EQ:  s_val = {63'd0, eq};
      OP_NE:  s_val = {63'd0, !eq};
      OP_LT:  s_val = {63'd0, lt};
      OP_LE:  s_val = {63'd0, lt || eq};
      OP_GT:  s_val = {63'd0, !lt && !eq};
      OP_GE:  s_val = {63'd0, !lt};
      OP_CMP: s_val = lt ? '1 : (eq ? '0 : 64'd1);
      OP_MAX: s_val = !lt ? a : b;
      OP_MIN: s_val = (lt || eq) ? a : b;
      default: s_val = '0;
    endcase
    if (s_err != ERR_NONE) begin
      s_val = '0;
    end else if (q_item.cmd <= OP_SHR || q_item.cmd == OP_MAX || q_item.cmd == OP_MIN) begin
      s_val = sext(s_val, q_item.wop);
    end
  end

  // Partial product operands, divider step and multiply range check.
  always_comb begin
    pa     = cnt[0] ? ma[63:32] : ma[31:0];
    pb     = cnt[1] ? mb[63:32] : mb[31:0];
    rem_sh = {rem[DataW-1:0], quo[DataW-1]};
    lo     = acc[DataW-1:0];
    lim    = cur_neg ? half_of(cur_wop) : (half_of(cur_wop) - 64'd1);
    mq     = (cur_cmd == OP_DIV) ? quo : rem[DataW-1:0];
  end

  assign q_pop = (state == ST_IDLE) && q_valid && (is_mul || is_long_div || out_free);

  // The output register loads a single-cycle result or a finished long operation.
  assign out_load = ((state == ST_IDLE) && q_valid && !is_mul && !is_long_div && out_free) ||
                    ((state == ST_DONE) && out_free);

  // Sequencer for the multi-cycle operations.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (is_mul) begin
              state <= ST_MUL;
              cnt   <= '0;
            end else if (is_long_div) begin
              state <= ST_DIV;
              cnt   <= '0;
            end
          end
        end
        ST_MUL: begin
          cnt <= cnt + 7'd1;
          if (cnt == 7'd5) state <= ST_DONE;
        end
        ST_DIV: begin
          cnt <= cnt + 7'd1;
          if (cnt == 7'd64) state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          cur_cmd   <= q_item.cmd;
          cur_wop   <= q_item.wop;
          cur_neg   <= a[63] ^ b[63];
          cur_a_neg <= a[63];
          ma        <= mag(a);
          mb        <= mag(b);
          acc       <= '0;
          rem       <= '0;
          quo       <= mag(a);
          if (!is_mul && !is_long_div && out_free) begin
            out_value <= s_val;
            out_err   <= s_err;
          end
        end
      end
      ST_MUL: begin
        if (cnt < 7'd4) begin
          prod    <= pa * pb;
          prod_sh <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
        end
        if (cnt != 7'd0 && cnt != 7'd5) begin
          acc <= acc + ({64'd0, prod} << (7'd32 * prod_sh));
        end
        if (cnt == 7'd5) begin
          if (acc[2*DataW-1:DataW] != '0 || lo > lim) begin
            res_value <= '0;
            res_err   <= ERR_OVF;
          end else begin
            res_value <= sext(cur_neg ? (~lo + 64'd1) : lo, cur_wop);
            res_err   <= ERR_NONE;
          end
        end
      end
      ST_DIV: begin
        if (cnt != 7'd64) begin
          if (rem_sh >= {1'b0, mb}) begin
            rem <= rem_sh - {1'b0, mb};
            quo <= {quo[DataW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[DataW-2:0], 1'b0};
          end
        end else begin
          if ((cur_cmd == OP_DIV) ? cur_neg : cur_a_neg) begin
            res_value <= sext(~mq + 64'd1, cur_wop);
          end else begin
            res_value <= sext(mq, cur_wop);
          end
          res_err <= ERR_NONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_value <= res_value;
          out_err   <= res_err;
        end
      end
      default: ;
    endcase
  end

endmodule
